// ===== rtl/core/lssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane segment steering decider package
// Shared widths, register indexes, reset values, steering codes and the
// fixed smoothing weights.
// ----------------------------------------------------------------------------
package lssd_pkg;

	// Field widths.
	localparam int COORD_W     = 10;
	localparam int SLOPE_W     = 12;
	localparam int MAG_W       = 10;
	localparam int OFFSET_W    = 9;
	localparam int COUNT_W     = 8;
	localparam int DUTY_W      = 20;
	localparam int DZ_W        = 8;
	localparam int CMD_W       = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	// Product and sum widths of the smoother.
	localparam int WEIGHT_W = 17;
	localparam int PROD_W   = OFFSET_W + WEIGHT_W;
	localparam int SUM_W    = PROD_W + 1;
	localparam int SHIFT_W  = 16;

	typedef logic [CMD_W-1:0]           cmd_t;
	typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
	typedef logic signed [OFFSET_W-1:0] offset_t;
	typedef logic signed [SLOPE_W-1:0]  slope_t;

	// Steering codes.
	localparam cmd_t CMD_FORWARD = 2'd0;
	localparam cmd_t CMD_LEFT    = 2'd1;
	localparam cmd_t CMD_RIGHT   = 2'd2;

	// Register indexes.
	localparam cfg_index_t REG_DEAD_ZONE     = 3'd0;
	localparam cfg_index_t REG_SLOPE_MIN     = 3'd1;
	localparam cfg_index_t REG_SLOPE_MAX     = 3'd2;
	localparam cfg_index_t REG_SINGLE_TURN   = 3'd3;
	localparam cfg_index_t REG_MEMORY_TURN   = 3'd4;
	localparam cfg_index_t REG_DUTY_STRAIGHT = 3'd5;
	localparam cfg_index_t REG_DUTY_FAST     = 3'd6;
	localparam cfg_index_t REG_DUTY_SLOW     = 3'd7;

	// Register reset values.
	localparam logic [DZ_W-1:0]   RST_DEAD_ZONE     = 8'd25;
	localparam logic [MAG_W-1:0]  RST_SLOPE_MIN     = 10'd51;
	localparam logic [MAG_W-1:0]  RST_SLOPE_MAX     = 10'd768;
	localparam logic [MAG_W-1:0]  RST_SINGLE_TURN   = 10'd563;
	localparam logic [MAG_W-1:0]  RST_MEMORY_TURN   = 10'd512;
	localparam logic [DUTY_W-1:0] RST_DUTY_STRAIGHT = 20'd140000;
	localparam logic [DUTY_W-1:0] RST_DUTY_FAST     = 20'd290000;
	localparam logic [DUTY_W-1:0] RST_DUTY_SLOW     = 20'd130000;

	// Slope saturation and kept-line count ceiling.
	localparam logic [MAG_W-1:0]   SLOPE_LIMIT = 10'd1023;
	localparam logic [COUNT_W-1:0] KEPT_MAX    = 8'd255;

	// Smoothing weights in Q16 (0.15 new, 0.85 old).
	localparam logic signed [WEIGHT_W-1:0] W_NEW = 17'sd9830;
	localparam logic signed [WEIGHT_W-1:0] W_OLD = 17'sd55706;

	// Smoothed offset limits.
	localparam logic signed [SLOPE_W-1:0] OFFSET_HI = 12'sd255;
	localparam logic signed [SLOPE_W-1:0] OFFSET_LO = -12'sd256;

endpackage

// ===== rtl/core/lssd_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial slope divider
// Restoring divider that forms (dividend << FRAC_BITS) / divisor, one
// quotient bit per cycle, and pulses done when the quotient is ready.
// ----------------------------------------------------------------------------
module lssd_divider import lssd_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [COORD_W-1:0]            dividend,
	input  logic [COORD_W-1:0]            divisor,
	output logic                          done,
	output logic [COORD_W+FRAC_BITS-1:0]  quotient
);

	localparam int NUM_W = COORD_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   quo_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [COORD_W:0]   shifted;
	logic [COORD_W+1:0] diff;
	logic               borrow;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, num_q[NUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		borrow  = diff[COORD_W+1];
	end

	// Control: counts one iteration per quotient bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: remainder, numerator shift line and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, {FRAC_BITS{1'b0}}};
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= borrow ? shifted[COORD_W-1:0] : diff[COORD_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ~borrow};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/lssd_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offset smoother
// Weights the new target offset and the previous smoothed offset in Q16,
// truncates toward zero and saturates to the nine-bit offset range.
// ----------------------------------------------------------------------------
module lssd_smoother import lssd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  offset_t target,
	input  offset_t previous,
	output logic    done,
	output offset_t smoothed
);

	logic signed [PROD_W-1:0] prod_new_s1;
	logic signed [PROD_W-1:0] prod_old_s1;
	logic                     valid_s1;
	logic                     done_q;
	offset_t                  smoothed_q;

	logic signed [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]          mag;
	logic [SUM_W-SHIFT_W-1:0]  mag_sh;
	logic signed [SLOPE_W-1:0] s_wide;

	// Valid flags of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			done_q   <= valid_s1;
		end
	end

	// First stage: the two weighted products.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_new_s1 <= target * W_NEW;
			prod_old_s1 <= previous * W_OLD;
		end
	end

	// Second stage: sum, truncation toward zero and saturation.
	always_comb begin
		sum    = {prod_new_s1[PROD_W-1], prod_new_s1} + {prod_old_s1[PROD_W-1], prod_old_s1};
		mag    = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
		mag_sh = mag[SUM_W-1:SHIFT_W];
		s_wide = sum[SUM_W-1] ? -$signed({1'b0, mag_sh}) : $signed({1'b0, mag_sh});
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (s_wide > OFFSET_HI) begin
				smoothed_q <= OFFSET_HI[OFFSET_W-1:0];
			end else if (s_wide < OFFSET_LO) begin
				smoothed_q <= OFFSET_LO[OFFSET_W-1:0];
			end else begin
				smoothed_q <= s_wide[OFFSET_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign smoothed = smoothed_q;

endmodule

// ===== rtl/core/lane_segment_steering_decider_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane segment steering decider
// Classifies a frame's line segments by slope, then at end of frame forms a
// smoothed target offset and a steering command with the wheel duties.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid / in_stall   func, x_start, y_start, x_end, y_end
//  out       source     out_valid / out_stall steer_command, left_side_duty,
//                                             right_side_duty, smoothed_offset,
//                                             kept_line_count
//  cfg       sink       cfg_write             cfg_index, cfg_data
//
// A segment occupies the block until the serial divider, which yields one
// quotient bit a cycle, has formed its whole quotient.
// A vertical segment is taken without a division. An end of frame passes
// through the two-stage smoother, then waits while a stalled result is held.
// Reset restores all register defaults and clears the frame and history state.
// The input is stalled whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module lane_segment_steering_decider_top import lssd_pkg::*; #(
	parameter int IMAGE_WIDTH     = 320,
	parameter int SLOPE_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	input  logic [COORD_W-1:0]    x_start,
	input  logic [COORD_W-1:0]    y_start,
	input  logic [COORD_W-1:0]    x_end,
	input  logic [COORD_W-1:0]    y_end,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CMD_W-1:0]      steer_command,
	output logic [DUTY_W-1:0]     left_side_duty,
	output logic [DUTY_W-1:0]     right_side_duty,
	output logic signed [OFFSET_W-1:0] smoothed_offset,
	output logic [COUNT_W-1:0]    kept_line_count,
	input  logic                  cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_W = COORD_W + SLOPE_FRAC_BITS;
	localparam logic signed [OFFSET_W-1:0] TARGET_OFS = OFFSET_W'(IMAGE_WIDTH / 4);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_FRAME = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	// Configuration registers.
	logic [DZ_W-1:0]   dead_zone_q;
	logic [MAG_W-1:0]  slope_min_q;
	logic [MAG_W-1:0]  slope_max_q;
	logic [MAG_W-1:0]  single_turn_q;
	logic [MAG_W-1:0]  memory_turn_q;
	logic [DUTY_W-1:0] duty_straight_q;
	logic [DUTY_W-1:0] duty_fast_q;
	logic [DUTY_W-1:0] duty_slow_q;

	// Sequencer and frame state.
	logic [1:0]         state_q;
	logic [COUNT_W-1:0] kept_count_q;
	logic               left_seen_q;
	logic               right_seen_q;
	slope_t             first_slope_q;
	offset_t            prev_offset_q;
	slope_t             remembered_q;
	logic               neg_q;

	// Output register.
	logic               out_valid_q;
	cmd_t               cmd_q;
	logic [DUTY_W-1:0]  lduty_q;
	logic [DUTY_W-1:0]  rduty_q;
	offset_t            offset_q;
	logic [COUNT_W-1:0] count_q;

	logic                     in_accept;
	logic signed [COORD_W:0]  dx;
	logic signed [COORD_W:0]  dy;
	logic [COORD_W:0]         ax_wide;
	logic [COORD_W:0]         ay_wide;
	logic                     div_start;
	logic                     div_done;
	logic [NUM_W-1:0]         div_quo;
	logic [MAG_W-1:0]         q_sat;
	logic                     keep;
	slope_t                   slope;
	logic                     sm_start;
	logic                     sm_done;
	offset_t                  sm_out;
	offset_t                  target;
	logic                     emit;
	cmd_t                     cmd;
	logic signed [COORD_W:0]  s_ext;
	logic signed [COORD_W:0]  dz_pos;
	slope_t                   single_thr;
	slope_t                   memory_thr;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Segment differences and their magnitudes.
	always_comb begin
		dx      = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
		dy      = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
		ax_wide = dx[COORD_W] ? -dx : dx;
		ay_wide = dy[COORD_W] ? -dy : dy;
	end

	assign div_start = in_accept && !func && (dx != '0);
	assign sm_start  = in_accept && func;

	lssd_divider #(
		.FRAC_BITS (SLOPE_FRAC_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ay_wide[COORD_W-1:0]),
		.divisor  (ax_wide[COORD_W-1:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Target offset from which sides were seen this frame.
	always_comb begin
		if (left_seen_q && !right_seen_q) begin
			target = TARGET_OFS;
		end else if (right_seen_q && !left_seen_q) begin
			target = -TARGET_OFS;
		end else begin
			target = '0;
		end
	end

	lssd_smoother u_smoother (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sm_start),
		.target   (target),
		.previous (prev_offset_q),
		.done     (sm_done),
		.smoothed (sm_out)
	);

	// Slope saturation, band test and signed slope.
	always_comb begin
		q_sat = (div_quo > NUM_W'(SLOPE_LIMIT)) ? SLOPE_LIMIT : div_quo[MAG_W-1:0];
		keep  = (q_sat > slope_min_q) && (q_sat < slope_max_q);
		slope = neg_q ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
	end

	// Steering decision from the smoothed offset or the slopes.
	always_comb begin
		s_ext      = {{(COORD_W + 1 - OFFSET_W){sm_out[OFFSET_W-1]}}, sm_out};
		dz_pos     = $signed({{(COORD_W + 1 - DZ_W){1'b0}}, dead_zone_q});
		single_thr = $signed({2'b00, single_turn_q});
		memory_thr = $signed({2'b00, memory_turn_q});
		if (kept_count_q >= 8'd2) begin
			if (s_ext <= dz_pos && s_ext >= -dz_pos) begin
				cmd = CMD_FORWARD;
			end else if (s_ext < -dz_pos) begin
				cmd = CMD_LEFT;
			end else begin
				cmd = CMD_RIGHT;
			end
		end else if (kept_count_q == 8'd1) begin
			if (first_slope_q < -single_thr) begin
				cmd = CMD_LEFT;
			end else if (first_slope_q > single_thr) begin
				cmd = CMD_RIGHT;
			end else begin
				cmd = CMD_FORWARD;
			end
		end else begin
			if (remembered_q < -memory_thr) begin
				cmd = CMD_RIGHT;
			end else if (remembered_q > memory_thr) begin
				cmd = CMD_LEFT;
			end else begin
				cmd = CMD_FORWARD;
			end
		end
	end

	assign emit = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q     <= RST_DEAD_ZONE;
			slope_min_q     <= RST_SLOPE_MIN;
			slope_max_q     <= RST_SLOPE_MAX;
			single_turn_q   <= RST_SINGLE_TURN;
			memory_turn_q   <= RST_MEMORY_TURN;
			duty_straight_q <= RST_DUTY_STRAIGHT;
			duty_fast_q     <= RST_DUTY_FAST;
			duty_slow_q     <= RST_DUTY_SLOW;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEAD_ZONE:     dead_zone_q     <= cfg_data[DZ_W-1:0];
				REG_SLOPE_MIN:     slope_min_q     <= cfg_data[MAG_W-1:0];
				REG_SLOPE_MAX:     slope_max_q     <= cfg_data[MAG_W-1:0];
				REG_SINGLE_TURN:   single_turn_q   <= cfg_data[MAG_W-1:0];
				REG_MEMORY_TURN:   memory_turn_q   <= cfg_data[MAG_W-1:0];
				REG_DUTY_STRAIGHT: duty_straight_q <= cfg_data[DUTY_W-1:0];
				REG_DUTY_FAST:     duty_fast_q     <= cfg_data[DUTY_W-1:0];
				REG_DUTY_SLOW:     duty_slow_q     <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			kept_count_q  <= '0;
			left_seen_q   <= 1'b0;
			right_seen_q  <= 1'b0;
			first_slope_q <= '0;
			prev_offset_q <= '0;
			remembered_q  <= '0;
			neg_q         <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						neg_q   <= dx[COORD_W] ^ dy[COORD_W];
						state_q <= ST_DIV;
					end else if (sm_start) begin
						state_q <= ST_FRAME;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (keep) begin
							if (kept_count_q == '0) begin
								first_slope_q <= slope;
							end
							if (kept_count_q != KEPT_MAX) begin
								kept_count_q <= kept_count_q + 1'b1;
							end
							if (neg_q) begin
								left_seen_q <= 1'b1;
							end else begin
								right_seen_q <= 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FRAME: begin
					if (sm_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						prev_offset_q <= sm_out;
						if (kept_count_q == 8'd1) begin
							remembered_q <= first_slope_q;
						end
						kept_count_q <= '0;
						left_seen_q  <= 1'b0;
						right_seen_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload with the duty selection.
	always_ff @(posedge clk) begin
		if (emit) begin
			cmd_q    <= cmd;
			offset_q <= sm_out;
			count_q  <= kept_count_q;
			case (cmd)
				CMD_FORWARD: begin
					lduty_q <= duty_straight_q;
					rduty_q <= duty_straight_q;
				end
				CMD_LEFT: begin
					lduty_q <= duty_fast_q;
					rduty_q <= duty_slow_q;
				end
				default: begin
					lduty_q <= duty_slow_q;
					rduty_q <= duty_fast_q;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign steer_command   = cmd_q;
	assign left_side_duty  = lduty_q;
	assign right_side_duty = rduty_q;
	assign smoothed_offset = offset_q;
	assign kept_line_count = count_q;

	// A quotient only arrives while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	// A smoothed offset only arrives while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		sm_done |-> state_q == ST_FRAME)
		else $error("smoother finished outside the frame state");

	// A side can only be marked once a line has been kept.
	assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q == '0 |-> !left_seen_q && !right_seen_q)
		else $error("side marked with no kept line");

	// Emitting a result clears the frame and presents a valid result.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q && kept_count_q == '0 && state_q == ST_IDLE)
		else $error("frame state not cleared after a result transfer was loaded");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane segment steering decider testbench
// Feeds frames of line segments, each closed by an end-of-frame transfer,
// through the valid/stall input channel. The bench works out each frame's
// steering command, wheel duties, smoothed offset and kept-line count on its
// own, and checks every output transfer against it. The slope thresholds,
// dead zone and duties are rewritten between phases, extremes included.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
	import lssd_pkg::*;

	localparam int IMG_W         = 320;
	localparam int FRAC_BITS     = 8;
	localparam int SETTLE_CYCLES = FRAC_BITS + 12 + 8;
	localparam int PHASE_ITEMS   = 30;
	localparam int TIMEOUT_NS    = 3_000_000;

	typedef struct {
		logic               func;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
	} lane_item_t;

	typedef struct {
		cmd_t                cmd;
		logic [DUTY_W-1:0]   left_duty;
		logic [DUTY_W-1:0]   right_duty;
		offset_t             offset;
		logic [COUNT_W-1:0]  kept;
	} steer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [COORD_W-1:0] x_start = '0;
	logic [COORD_W-1:0] y_start = '0;
	logic [COORD_W-1:0] x_end = '0;
	logic [COORD_W-1:0] y_end = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CMD_W-1:0] steer_command;
	logic [DUTY_W-1:0] left_side_duty;
	logic [DUTY_W-1:0] right_side_duty;
	logic signed [OFFSET_W-1:0] smoothed_offset;
	logic [COUNT_W-1:0] kept_line_count;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lane_item_t    pending_items[$];
	steer_result_t expected_steer[$];
	lane_item_t    cur_item;
	int            send_gap = 0;
	int            recv_gap = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;
	int            fault_count = 0;
	int            queued_items = 0;

	// Shadow copies of the registers and of the frame and history state.
	int unsigned cfg_dead_zone, cfg_slope_min, cfg_slope_max, cfg_single_turn;
	int unsigned cfg_memory_turn, cfg_duty_straight, cfg_duty_fast, cfg_duty_slow;
	int          frame_kept;
	bit          frame_left, frame_right;
	int          first_slope, prev_offset, held_slope;

	lane_segment_steering_decider_top #(
		.IMAGE_WIDTH     (IMG_W),
		.SLOPE_FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.x_start         (x_start),
		.y_start         (y_start),
		.x_end           (x_end),
		.y_end           (y_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.steer_command   (steer_command),
		.left_side_duty  (left_side_duty),
		.right_side_duty (right_side_duty),
		.smoothed_offset (smoothed_offset),
		.kept_line_count (kept_line_count),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #4 clk = ~clk;

	// Bring the shadow registers and state to their reset values.
	function automatic void reset_shadow();
		cfg_dead_zone     = RST_DEAD_ZONE;
		cfg_slope_min     = RST_SLOPE_MIN;
		cfg_slope_max     = RST_SLOPE_MAX;
		cfg_single_turn   = RST_SINGLE_TURN;
		cfg_memory_turn   = RST_MEMORY_TURN;
		cfg_duty_straight = RST_DUTY_STRAIGHT;
		cfg_duty_fast     = RST_DUTY_FAST;
		cfg_duty_slow     = RST_DUTY_SLOW;
		frame_kept        = 0;
		frame_left        = 1'b0;
		frame_right       = 1'b0;
		first_slope       = 0;
		prev_offset       = 0;
		held_slope        = 0;
	endfunction

	// Classify one segment by its saturated fixed-point slope.
	function automatic void absorb_segment(lane_item_t it);
		int dx, dy, ax, ay, q, slope;
		dx = it.x_end;
		dx = dx - int'(it.x_start);
		dy = it.y_end;
		dy = dy - int'(it.y_start);
		if (dx == 0) begin
			return;
		end
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		q = (ay << FRAC_BITS) / ax;
		if (q > int'(SLOPE_LIMIT)) begin
			q = SLOPE_LIMIT;
		end
		if (!(q > int'(cfg_slope_min) && q < int'(cfg_slope_max))) begin
			return;
		end
		slope = ((dx < 0) != (dy < 0)) ? -q : q;
		if (frame_kept == 0) begin
			first_slope = slope;
		end
		if (frame_kept < int'(KEPT_MAX)) begin
			frame_kept++;
		end
		if (slope < 0) begin
			frame_left = 1'b1;
		end else begin
			frame_right = 1'b1;
		end
	endfunction

	// Close a frame: smooth the target offset and pick the steering command.
	function automatic void close_frame();
		int            target, s, dz, thr;
		longint        acc, mag;
		steer_result_t r;
		target = 0;
		if (frame_left && !frame_right) begin
			target = IMG_W / 4;
		end else if (frame_right && !frame_left) begin
			target = -(IMG_W / 4);
		end
		acc = longint'(target) * longint'(W_NEW) + longint'(prev_offset) * longint'(W_OLD);
		mag = ((acc < 0) ? -acc : acc) / 65536;
		s = (acc < 0) ? -int'(mag) : int'(mag);
		if (s > 255) begin
			s = 255;
		end
		if (s < -256) begin
			s = -256;
		end
		prev_offset = s;

		if (frame_kept >= 2) begin
			dz = cfg_dead_zone;
			if (s <= dz && s >= -dz) begin
				r.cmd = CMD_FORWARD;
			end else if (s < -dz) begin
				r.cmd = CMD_LEFT;
			end else begin
				r.cmd = CMD_RIGHT;
			end
		end else if (frame_kept == 1) begin
			held_slope = first_slope;
			thr = cfg_single_turn;
			if (first_slope < -thr) begin
				r.cmd = CMD_LEFT;
			end else if (first_slope > thr) begin
				r.cmd = CMD_RIGHT;
			end else begin
				r.cmd = CMD_FORWARD;
			end
		end else begin
			// An empty frame steers away from the side of the remembered line.
			thr = cfg_memory_turn;
			if (held_slope < -thr) begin
				r.cmd = CMD_RIGHT;
			end else if (held_slope > thr) begin
				r.cmd = CMD_LEFT;
			end else begin
				r.cmd = CMD_FORWARD;
			end
		end

		case (r.cmd)
			CMD_FORWARD: begin
				r.left_duty  = DUTY_W'(cfg_duty_straight);
				r.right_duty = DUTY_W'(cfg_duty_straight);
			end
			CMD_LEFT: begin
				r.left_duty  = DUTY_W'(cfg_duty_fast);
				r.right_duty = DUTY_W'(cfg_duty_slow);
			end
			default: begin
				r.left_duty  = DUTY_W'(cfg_duty_slow);
				r.right_duty = DUTY_W'(cfg_duty_fast);
			end
		endcase
		r.offset = OFFSET_W'(s);
		r.kept   = COUNT_W'(frame_kept);
		expected_steer.insert(expected_steer.size(), r);

		frame_kept  = 0;
		frame_left  = 1'b0;
		frame_right = 1'b0;
	endfunction

	// Input driver: presents queued items and idles in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func     <= 1'b0;
			x_start  <= '0;
			y_start  <= '0;
			x_end    <= '0;
			y_end    <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (cur_item.func) begin
					close_frame();
				end else begin
					absorb_segment(cur_item);
				end
			end
			// A stalled transfer holds its payload until it is taken.
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0 && $urandom_range(99, 0) < idle_pct) begin
					send_gap = $urandom_range(10, 0);
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					func     <= cur_item.func;
					x_start  <= cur_item.x_start;
					y_start  <= cur_item.y_start;
					x_end    <= cur_item.x_end;
					y_end    <= cur_item.y_end;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Compare one output transfer with the oldest expected result.
	task automatic check_steer();
		steer_result_t e;
		if (expected_steer.size() == 0) begin
			fault_count++;
			if (fault_count <= 10) begin
				$display("Unexpected result at %0t: command %0d, duties %0d/%0d, offset %0d",
					$time, steer_command, left_side_duty, right_side_duty, smoothed_offset);
			end
			return;
		end
		e = expected_steer.pop_front();
		if (steer_command !== e.cmd || left_side_duty !== e.left_duty ||
				right_side_duty !== e.right_duty || smoothed_offset !== e.offset ||
				kept_line_count !== e.kept) begin
			fault_count++;
			if (fault_count <= 10) begin
				$display("Mismatch at %0t (expected/actual): command %0d/%0d, left %0d/%0d, right %0d/%0d, offset %0d/%0d, lines %0d/%0d",
					$time, e.cmd, steer_command, e.left_duty, left_side_duty,
					e.right_duty, right_side_duty, e.offset, smoothed_offset,
					e.kept, kept_line_count);
			end
		end
	endtask

	// Output monitor: checks accepted transfers and stalls in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_steer();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if ($urandom_range(99, 0) < stall_pct) begin
				recv_gap = $urandom_range(10, 0);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Register write while the block is idle; the shadow copy follows it.
	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_DEAD_ZONE:     cfg_dead_zone     = val[DZ_W-1:0];
			REG_SLOPE_MIN:     cfg_slope_min     = val[MAG_W-1:0];
			REG_SLOPE_MAX:     cfg_slope_max     = val[MAG_W-1:0];
			REG_SINGLE_TURN:   cfg_single_turn   = val[MAG_W-1:0];
			REG_MEMORY_TURN:   cfg_memory_turn   = val[MAG_W-1:0];
			REG_DUTY_STRAIGHT: cfg_duty_straight = val;
			REG_DUTY_FAST:     cfg_duty_fast     = val;
			REG_DUTY_SLOW:     cfg_duty_slow     = val;
			default: ;
		endcase
	endtask

	task automatic write_all(int dz, int smin, int smax, int sturn, int mturn,
			int dstr, int dfast, int dslow);
		write_reg(REG_DEAD_ZONE, CFG_DATA_W'(dz));
		write_reg(REG_SLOPE_MIN, CFG_DATA_W'(smin));
		write_reg(REG_SLOPE_MAX, CFG_DATA_W'(smax));
		write_reg(REG_SINGLE_TURN, CFG_DATA_W'(sturn));
		write_reg(REG_MEMORY_TURN, CFG_DATA_W'(mturn));
		write_reg(REG_DUTY_STRAIGHT, CFG_DATA_W'(dstr));
		write_reg(REG_DUTY_FAST, CFG_DATA_W'(dfast));
		write_reg(REG_DUTY_SLOW, CFG_DATA_W'(dslow));
	endtask

	task automatic push_seg(int xs, int ys, int xe, int ye);
		lane_item_t it;
		it.func    = 1'b0;
		it.x_start = COORD_W'(xs);
		it.y_start = COORD_W'(ys);
		it.x_end   = COORD_W'(xe);
		it.y_end   = COORD_W'(ye);
		pending_items.insert(pending_items.size(), it);
		queued_items++;
	endtask

	// End of frame; its coordinates are noise that the block ignores.
	task automatic push_eof();
		lane_item_t it;
		it.func    = 1'b1;
		it.x_start = COORD_W'($urandom);
		it.y_start = COORD_W'($urandom);
		it.x_end   = COORD_W'($urandom);
		it.y_end   = COORD_W'($urandom);
		pending_items.insert(pending_items.size(), it);
		queued_items++;
	endtask

	// Random segment: mostly lane-like slopes, some noise, vertical,
	// horizontal and overflowing ones. With in_band set the slope always
	// falls inside the default band.
	function automatic lane_item_t random_segment(bit in_band);
		lane_item_t it;
		int         kind, ax, ay, xl, yl;
		it.func = 1'b0;
		kind = in_band ? 9 : $urandom_range(9, 0);
		ax = 0;
		ay = 0;
		case (kind)
			0: begin
				it.x_start = COORD_W'($urandom);
				it.y_start = COORD_W'($urandom);
				it.x_end   = COORD_W'($urandom);
				it.y_end   = COORD_W'($urandom);
			end
			1: begin
				it.x_start = COORD_W'($urandom);
				it.x_end   = it.x_start;
				it.y_start = COORD_W'($urandom);
				it.y_end   = COORD_W'($urandom);
			end
			2: begin
				it.x_start = COORD_W'($urandom);
				it.x_end   = COORD_W'($urandom);
				it.y_start = COORD_W'($urandom);
				it.y_end   = it.y_start;
			end
			3: begin
				ax = $urandom_range(3, 1);
				ay = $urandom_range(1023, 300);
			end
			default: begin
				ax = in_band ? $urandom_range(400, 20) : $urandom_range(400, 1);
				ay = ax * (in_band ? $urandom_range(280, 30) : $urandom_range(400, 5)) / 100;
				if (ay > 1023) begin
					ay = 1023;
				end
			end
		endcase
		if (kind >= 3) begin
			xl = $urandom_range(1023 - ax, 0);
			yl = $urandom_range(1023 - ay, 0);
			if ($urandom_range(1, 0)) begin
				it.x_start = COORD_W'(xl);
				it.x_end   = COORD_W'(xl + ax);
			end else begin
				it.x_start = COORD_W'(xl + ax);
				it.x_end   = COORD_W'(xl);
			end
			if ($urandom_range(1, 0)) begin
				it.y_start = COORD_W'(yl);
				it.y_end   = COORD_W'(yl + ay);
			end else begin
				it.y_start = COORD_W'(yl + ay);
				it.y_end   = COORD_W'(yl);
			end
		end
		return it;
	endfunction

	task automatic queue_random_frame();
		int pick, n;
		pick = $urandom_range(99, 0);
		if (pick < 15) begin
			n = 0;
		end else if (pick < 40) begin
			n = 1;
		end else if (pick < 65) begin
			n = 2;
		end else begin
			n = $urandom_range(6, 3);
		end
		repeat (n) begin
			pending_items.insert(pending_items.size(), random_segment(1'b0));
			queued_items++;
		end
		push_eof();
	endtask

	// Hold the sender until every expected result has come, then let the
	// block finish any slope division still under way.
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_steer.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus sequence.
	initial begin
		reset_shadow();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset settings.
		idle_pct  = 25;
		stall_pct = 25;
		push_eof();
		push_seg(0, 1023, 1023, 0);
		push_eof();
		push_seg(100, 0, 0, 250);
		push_eof();
		push_seg(0, 0, 100, 250);
		push_eof();
		push_eof();
		// Vertical, flat, overflowing and corner-to-corner segments.
		push_seg(5, 0, 5, 1023);
		push_seg(0, 7, 1023, 7);
		push_seg(0, 0, 1, 1023);
		push_seg(1023, 1023, 0, 0);
		push_eof();
		// Left-only frames drive the smoothed offset past the dead zone.
		repeat (3) begin
			push_seg(0, 1023, 1023, 0);
			push_seg(1023, 0, 0, 1023);
			push_eof();
		end
		push_seg(0, 1023, 1023, 0);
		push_seg(0, 0, 1023, 1023);
		push_eof();
		wait_drained();

		// Random phases, each under its own register settings.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				1: write_all(0, 0, 1023, 0, 0, 0, 1000000, 1);
				2: write_all(255, 1023, 0, 1023, 1023, 1000000, 1000000, 0);
				3: write_all(RST_DEAD_ZONE, RST_SLOPE_MIN, RST_SLOPE_MAX, RST_SINGLE_TURN,
					RST_MEMORY_TURN, RST_DUTY_STRAIGHT, RST_DUTY_FAST, RST_DUTY_SLOW);
				default: write_all($urandom_range(255, 0), $urandom_range(300, 0),
					$urandom_range(1023, 400), $urandom_range(1023, 0),
					$urandom_range(1023, 0), $urandom_range(1000000, 0),
					$urandom_range(1000000, 0), $urandom_range(1000000, 0));
			endcase
			if (phase == 1 || phase == 6) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = $urandom_range(40, 15);
				stall_pct = $urandom_range(40, 15);
			end
			if (phase == 3) begin
				// More kept lines than the count can hold.
				repeat (260) begin
					pending_items.insert(pending_items.size(), random_segment(1'b1));
					queued_items++;
				end
				push_eof();
			end
			queued_items = 0;
			while (queued_items < PHASE_ITEMS) begin
				queue_random_frame();
				if (phase == 4 && queued_items >= PHASE_ITEMS / 2 && queued_items < PHASE_ITEMS / 2 + 4) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		if (fault_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
